/* rtl/core/wssc_pkg.sv */
package wssc_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_AW   = $clog2(NUM_SLOTS);
    localparam int KEY_W     = 32;
    localparam int COUNT_W   = 32;
    localparam int REM_W     = 16;
    localparam int STEP_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int SUM_W     = 17;
    localparam int EST_W     = 48;
    localparam int ACTION_W  = 2;
    localparam int DIV_CW    = $clog2(SUM_W + 1);

    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [REM_W-1:0]   rem;
    } slot_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } div_rsp_t;

endpackage

/* rtl/core/wssc_slot_ram.sv */
module wssc_slot_ram (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [wssc_pkg::SLOT_AW-1:0] waddr,
    input  wssc_pkg::slot_t              wdata,
    input  logic [wssc_pkg::SLOT_AW-1:0] raddr,
    output wssc_pkg::slot_t              rdata
);

    wssc_pkg::slot_t mem [wssc_pkg::NUM_SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/wssc_divider.sv */
module wssc_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  wssc_pkg::div_req_t req,
    output wssc_pkg::div_rsp_t rsp
);

    logic [wssc_pkg::SUM_W-1:0]  quo_reg, quo_next;
    logic [wssc_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [wssc_pkg::STEP_W-1:0] dvs_reg;
    logic [wssc_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [wssc_pkg::SUM_W-1:0]  trial;
    logic                        ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial    = {rem_reg, quo_reg[wssc_pkg::SUM_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        quo_next = {quo_reg[wssc_pkg::SUM_W-2:0], ge};
        rem_next = ge ? wssc_pkg::REM_W'(trial - {1'b0, dvs_reg})
                      : trial[wssc_pkg::REM_W-1:0];
        cnt_next  = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != wssc_pkg::DIV_CW'(1));
        done_next = busy_reg && (cnt_reg == wssc_pkg::DIV_CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= wssc_pkg::DIV_CW'(wssc_pkg::SUM_W);
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* rtl/core/weighted_space_saving_counters_core.sv */
// channel   | direction | handshake          | word
// ----------+-----------+--------------------+---------------------------------
// s_        | in        | s_valid / s_ready  | s_action, s_key, s_weight
// m_        | out       | m_valid / m_ready  | m_estimate, m_tracked (query only)
// cfg_      | in        | cfg_we             | cfg_wdata (step size)
//
// Clear needs no scan. Query and update both scan the 64-entry slot memory
// one entry per cycle through its single read port, and an update then runs a
// bit-serial divide by the step size.
// Reset (synchronous, active low) marks every slot unused; no clearing pass.
// One word is worked on at a time; a finished estimate waits in the output
// register while the next word is taken.
module weighted_space_saving_counters_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [wssc_pkg::ACTION_W-1:0]        s_action,
    input  logic [wssc_pkg::KEY_W-1:0]           s_key,
    input  logic [wssc_pkg::WEIGHT_W-1:0]        s_weight,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [wssc_pkg::EST_W-1:0]           m_estimate,
    output logic                                 m_tracked,
    input  logic                                 cfg_we,
    input  logic [wssc_pkg::STEP_W-1:0]          cfg_wdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_WR     = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam int AW = wssc_pkg::SLOT_AW;

    logic [2:0]                     state_reg, state_next;
    logic [wssc_pkg::STEP_W-1:0]    step_reg;
    logic [wssc_pkg::STEP_W-1:0]    eff_step;
    logic [wssc_pkg::NUM_SLOTS-1:0] used_reg;

    // latched word
    logic [wssc_pkg::ACTION_W-1:0]  act_reg;
    logic [wssc_pkg::KEY_W-1:0]     key_reg;
    logic [wssc_pkg::WEIGHT_W-1:0]  wgt_reg;

    // scan bookkeeping
    logic [AW:0]                    addr_reg;
    logic                           rd_vld_reg;
    logic [AW-1:0]                  rd_idx_reg;
    logic                           hit_reg;
    logic [AW-1:0]                  hit_idx_reg;
    logic [wssc_pkg::COUNT_W-1:0]   hit_cnt_reg;
    logic [wssc_pkg::REM_W-1:0]     hit_rem_reg;
    logic                           free_reg;
    logic [AW-1:0]                  free_idx_reg;
    logic [AW-1:0]                  min_idx_reg;
    logic [wssc_pkg::COUNT_W-1:0]   min_cnt_reg;

    // write-back target
    logic [AW-1:0]                  tgt_idx_reg;
    logic [wssc_pkg::COUNT_W-1:0]   tgt_cnt_reg;
    logic [wssc_pkg::EST_W-1:0]     mul_reg;

    logic                           m_valid_reg;
    logic [wssc_pkg::EST_W-1:0]     m_est_reg;
    logic                           m_trk_reg;

    wssc_pkg::slot_t                rd_data;
    wssc_pkg::slot_t                wr_data;
    logic                           wr_en;
    wssc_pkg::div_req_t             div_req;
    wssc_pkg::div_rsp_t             div_rsp;

    logic                           accept;
    logic                           rd_used;
    logic [wssc_pkg::COUNT_W-1:0]   rd_cnt;
    logic [wssc_pkg::COUNT_W:0]     cnt_sum;
    logic                           out_free;
    logic [wssc_pkg::EST_W-1:0]     est_val;

    assign eff_step = (step_reg == '0) ? wssc_pkg::STEP_W'(1) : step_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // an unused slot reads as count zero
    assign rd_used = used_reg[rd_idx_reg];
    assign rd_cnt  = rd_used ? rd_data.count : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= wssc_pkg::STEP_W'(1);
        end else if (cfg_we) begin
            step_reg <= cfg_wdata;
        end
    end

    wssc_slot_ram u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (tgt_idx_reg),
        .wdata (wr_data),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rd_data)
    );

    wssc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // saturate the count at all ones
    assign cnt_sum = {1'b0, tgt_cnt_reg}
                   + {{(wssc_pkg::COUNT_W + 1 - wssc_pkg::SUM_W){1'b0}}, div_rsp.quo};
    assign wr_en        = (state_reg == ST_WR);
    assign wr_data.key   = key_reg;
    assign wr_data.count = cnt_sum[wssc_pkg::COUNT_W] ? '1 : cnt_sum[wssc_pkg::COUNT_W-1:0];
    assign wr_data.rem   = div_rsp.rem;

    // work out what goes into the divider from the slot an update lands in
    always_comb begin
        div_req.start    = (state_reg == ST_DECIDE) && (act_reg == wssc_pkg::ACT_UPDATE);
        div_req.divisor  = eff_step;
        if (hit_reg) begin
            div_req.dividend = {1'b0, wgt_reg} + {1'b0, hit_rem_reg};
        end else if (free_reg) begin
            div_req.dividend = {1'b0, wgt_reg};
        end else begin
            div_req.dividend = {1'b0, wgt_reg} + {1'b0, eff_step} - wssc_pkg::SUM_W'(1);
        end
    end

    always_comb begin
        if (hit_reg) begin
            est_val = mul_reg + {{(wssc_pkg::EST_W - wssc_pkg::REM_W){1'b0}}, hit_rem_reg};
        end else if ((&used_reg) && (min_cnt_reg != '0)) begin
            est_val = mul_reg - wssc_pkg::EST_W'(1);
        end else begin
            est_val = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_action == wssc_pkg::ACT_UPDATE ||
                               s_action == wssc_pkg::ACT_QUERY)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg && rd_idx_reg == AW'(wssc_pkg::NUM_SLOTS - 1)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = (act_reg == wssc_pkg::ACT_UPDATE) ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_WR;
                end
            end
            ST_WR:  state_next = ST_IDLE;
            ST_MUL: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // drop the whole table in one go
            if (accept && s_action == wssc_pkg::ACT_CLEAR) begin
                used_reg <= '0;
            end
            if (accept) begin
                addr_reg <= '0;
            end else if (state_reg == ST_SCAN &&
                         addr_reg < (AW + 1)'(wssc_pkg::NUM_SLOTS)) begin
                addr_reg <= addr_reg + 1'b1;
            end
            rd_vld_reg <= (state_reg == ST_SCAN) &&
                          (addr_reg < (AW + 1)'(wssc_pkg::NUM_SLOTS));
            if (state_reg == ST_WR) begin
                used_reg[tgt_idx_reg] <= 1'b1;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= addr_reg[AW-1:0];
        if (accept) begin
            act_reg  <= s_action;
            key_reg  <= s_key;
            wgt_reg  <= s_weight;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN && rd_vld_reg) begin
            if (rd_used && !hit_reg && rd_data.key == key_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
                hit_cnt_reg <= rd_data.count;
                hit_rem_reg <= rd_data.rem;
            end
            if (!rd_used && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            // strict less keeps the lowest index on a tie
            if (rd_idx_reg == '0 || rd_cnt < min_cnt_reg) begin
                min_idx_reg <= rd_idx_reg;
                min_cnt_reg <= rd_cnt;
            end
        end
        if (state_reg == ST_DECIDE) begin
            if (hit_reg) begin
                tgt_idx_reg <= hit_idx_reg;
                tgt_cnt_reg <= hit_cnt_reg;
            end else if (free_reg) begin
                tgt_idx_reg <= free_idx_reg;
                tgt_cnt_reg <= '0;
            end else begin
                tgt_idx_reg <= min_idx_reg;
                tgt_cnt_reg <= min_cnt_reg;
            end
        end
        if (state_reg == ST_MUL) begin
            mul_reg <= (hit_reg ? hit_cnt_reg : min_cnt_reg) * eff_step;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_est_reg <= est_val;
            m_trk_reg <= hit_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_estimate = m_est_reg;
    assign m_tracked  = m_trk_reg;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");

    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_SCAN))
        else $error("slot read outside scan");

    a_wb_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR) |=> used_reg[$past(tgt_idx_reg)])
        else $error("written slot not marked used");

    a_div_only_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (act_reg == wssc_pkg::ACT_UPDATE))
        else $error("divide on a non-update word");

endmodule

/* dv/weighted_space_saving_counters_core_tb.sv */
module weighted_space_saving_counters_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // word presented on the input channel
    typedef struct {
        logic [wssc_pkg::ACTION_W-1:0] action;
        logic [wssc_pkg::KEY_W-1:0]    key;
        logic [wssc_pkg::WEIGHT_W-1:0] weight;
    } hh_word_t;

    // estimate word as it should leave the result channel
    typedef struct {
        logic [wssc_pkg::EST_W-1:0] estimate;
        logic                       tracked;
    } hh_estimate_t;

    localparam logic [wssc_pkg::ACTION_W-1:0] ACT_IGNORED = 2'd3;
    localparam int SETTLE_CYCLES = 150;   // longer than one update's scan and divide

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [wssc_pkg::ACTION_W-1:0] s_action = wssc_pkg::ACT_UPDATE;
    logic [wssc_pkg::KEY_W-1:0]    s_key = '0;
    logic [wssc_pkg::WEIGHT_W-1:0] s_weight = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [wssc_pkg::EST_W-1:0]    m_estimate;
    logic                          m_tracked;
    logic                          cfg_we = 1'b0;
    logic [wssc_pkg::STEP_W-1:0]   cfg_wdata = '0;

    hh_word_t     pending_words[$];
    hh_estimate_t expected_estimates[$];
    int           sent_cnt = 0;
    int           taken_cnt = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           errors = 0;

    // shadow of the heavy-hitter table
    logic [wssc_pkg::KEY_W-1:0]   tab_key[wssc_pkg::NUM_SLOTS];
    logic [wssc_pkg::COUNT_W-1:0] tab_cnt[wssc_pkg::NUM_SLOTS];
    logic [wssc_pkg::REM_W-1:0]   tab_rem[wssc_pkg::NUM_SLOTS];
    bit                           tab_used[wssc_pkg::NUM_SLOTS];
    int                           tab_free;
    logic [wssc_pkg::STEP_W-1:0]  step_reg;

    logic [wssc_pkg::KEY_W-1:0]   key_pool[90];

    weighted_space_saving_counters_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_key     (s_key),
        .s_weight  (s_weight),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_estimate(m_estimate),
        .m_tracked (m_tracked),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint unsigned step_units();
        return (step_reg == '0) ? 1 : longint'(step_reg);
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < wssc_pkg::NUM_SLOTS; i++) begin
            tab_key[i]  = '0;
            tab_cnt[i]  = '0;
            tab_rem[i]  = '0;
            tab_used[i] = 1'b0;
        end
        tab_free = wssc_pkg::NUM_SLOTS;
    endfunction

    function automatic int find_slot(logic [wssc_pkg::KEY_W-1:0] k);
        for (int i = 0; i < wssc_pkg::NUM_SLOTS; i++)
            if (tab_used[i] && tab_key[i] == k)
                return i;
        return -1;
    endfunction

    // smallest count, lowest index on a tie
    function automatic int min_slot();
        int best;
        best = 0;
        for (int i = 1; i < wssc_pkg::NUM_SLOTS; i++)
            if (tab_cnt[i] < tab_cnt[best])
                best = i;
        return best;
    endfunction

    // fold a weight sum into a slot: whole steps to the count, saturating
    function automatic void fold_into(int s, longint unsigned sum);
        longint unsigned c;
        c = longint'(tab_cnt[s]) + sum / step_units();
        tab_cnt[s] = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
        tab_rem[s] = wssc_pkg::REM_W'(sum % step_units());
    endfunction

    function automatic void count_update(logic [wssc_pkg::KEY_W-1:0] k,
                                         logic [wssc_pkg::WEIGHT_W-1:0] w);
        int s;
        s = find_slot(k);
        if (s >= 0) begin
            fold_into(s, longint'(w) + longint'(tab_rem[s]));
            return;
        end
        if (tab_free > 0) begin
            for (int i = 0; i < wssc_pkg::NUM_SLOTS; i++) begin
                if (!tab_used[i]) begin
                    tab_used[i] = 1'b1;
                    tab_key[i]  = k;
                    tab_cnt[i]  = '0;
                    tab_rem[i]  = '0;
                    tab_free--;
                    fold_into(i, longint'(w));
                    return;
                end
            end
            tab_free = 0;
        end
        // evict the weakest slot, charging it the worst-case lost remainder
        s = min_slot();
        tab_key[s]  = k;
        tab_used[s] = 1'b1;
        fold_into(s, longint'(w) + step_units() - 1);
    endfunction

    function automatic hh_estimate_t estimate_of(logic [wssc_pkg::KEY_W-1:0] k);
        hh_estimate_t r;
        int s;
        longint unsigned m;
        s = find_slot(k);
        r.estimate = '0;
        r.tracked  = 1'b0;
        if (s >= 0) begin
            r.estimate = wssc_pkg::EST_W'(longint'(tab_cnt[s]) * step_units()
                                          + longint'(tab_rem[s]));
            r.tracked  = 1'b1;
        end else if (tab_free == 0) begin
            m = longint'(tab_cnt[min_slot()]);
            if (m != 0)
                r.estimate = wssc_pkg::EST_W'(m * step_units() - 1);
        end
        return r;
    endfunction

    // Drive on the falling edge. Hold the word until the monitor has seen it taken.
    always @(negedge aclk) begin
        hh_word_t w;
        if (aresetn) begin
            if (s_valid && taken_cnt != sent_cnt) begin
                // hold
            end else if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                w = pending_words.pop_front();
                s_valid  <= 1'b1;
                s_action <= w.action;
                s_key    <= w.key;
                s_weight <= w.weight;
                sent_cnt++;
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Sample on the rising edge: advance the shadow table on every accepted word
    // and check each estimate against the oldest one predicted.
    always @(posedge aclk) begin
        hh_estimate_t exp_e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected estimate %h tracked %b",
                             $realtime, m_estimate, m_tracked);
                    errors++;
                end else begin
                    exp_e = expected_estimates.pop_front();
                    if (m_estimate !== exp_e.estimate) begin
                        $display("%0t: estimate expected %h actual %h",
                                 $realtime, exp_e.estimate, m_estimate);
                        errors++;
                    end
                    if (m_tracked !== exp_e.tracked) begin
                        $display("%0t: tracked expected %b actual %b",
                                 $realtime, exp_e.tracked, m_tracked);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                taken_cnt++;
                case (s_action)
                    wssc_pkg::ACT_UPDATE: count_update(s_key, s_weight);
                    wssc_pkg::ACT_QUERY:  expected_estimates.push_back(estimate_of(s_key));
                    wssc_pkg::ACT_CLEAR:  table_clear();
                    default:              ;   // drop: unknown action
                endcase
            end
        end
    end

    task automatic queue_word(logic [wssc_pkg::ACTION_W-1:0] a,
                              logic [wssc_pkg::KEY_W-1:0] k,
                              logic [wssc_pkg::WEIGHT_W-1:0] w);
        hh_word_t x;
        x.action = a;
        x.key    = k;
        x.weight = w;
        pending_words.push_back(x);
    endtask

    // Wait until every word is taken and every estimate has come back, then
    // let a trailing update finish before touching the step register.
    task automatic drain();
        while (pending_words.size() > 0 || taken_cnt != sent_cnt
               || expected_estimates.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(logic [wssc_pkg::STEP_W-1:0] v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        step_reg  = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_words(int n);
        int r;
        logic [wssc_pkg::KEY_W-1:0]    k;
        logic [wssc_pkg::WEIGHT_W-1:0] w;
        for (int i = 0; i < n; i++) begin
            // mostly keys from a pool slightly larger than the table, so it
            // fills and starts evicting; now and then a fully random key
            k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(89)];
            case ($urandom_range(3))
                0:       w = wssc_pkg::WEIGHT_W'($urandom_range(15));
                1:       w = wssc_pkg::WEIGHT_W'(16'hFFFF - $urandom_range(15));
                default: w = wssc_pkg::WEIGHT_W'($urandom());
            endcase
            r = $urandom_range(99);
            if (r < 62)      queue_word(wssc_pkg::ACT_UPDATE, k, w);
            else if (r < 97) queue_word(wssc_pkg::ACT_QUERY, k, w);
            else if (r < 98) queue_word(wssc_pkg::ACT_CLEAR, k, w);
            else             queue_word(ACT_IGNORED, k, w);
        end
    endtask

    initial begin
        logic [wssc_pkg::STEP_W-1:0] steps[6];
        steps = '{16'd1, 16'd0, 16'hFFFF, 16'd7, 16'd1000, 16'd3};
        for (int i = 0; i < 90; i++)
            key_pool[i] = $urandom();
        step_reg = 16'd1;
        table_clear();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty table, field extremes, every action.
        queue_word(wssc_pkg::ACT_QUERY, 32'h0, 16'h0);
        queue_word(wssc_pkg::ACT_UPDATE, 32'h0, 16'h0);
        queue_word(wssc_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_word(wssc_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_word(wssc_pkg::ACT_QUERY, 32'h0, 16'hFFFF);
        queue_word(wssc_pkg::ACT_QUERY, 32'hFFFF_FFFF, 16'h0);
        queue_word(ACT_IGNORED, 32'hFFFF_FFFF, 16'hFFFF);
        queue_word(wssc_pkg::ACT_QUERY, 32'h5555_AAAA, 16'h0);
        queue_word(wssc_pkg::ACT_CLEAR, 32'h0, 16'h0);
        queue_word(wssc_pkg::ACT_QUERY, 32'hFFFF_FFFF, 16'h0);
        queue_word(wssc_pkg::ACT_UPDATE, 32'hAAAA_5555, 16'h1234);
        queue_word(wssc_pkg::ACT_QUERY, 32'hAAAA_5555, 16'h0);
        drain();

        // Phases: walk the step extremes (zero acts as one) and the idling mixes.
        // The table is kept across phases so it fills and evicts.
        for (int p = 0; p < 6; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            write_step(steps[p]);
            // small weights at a huge step leave counts at zero: hit the zero-minimum query
            if (p == 2)
                for (int i = 0; i < 4; i++)
                    queue_word(wssc_pkg::ACT_UPDATE, $urandom(), 16'd1);
            random_words(100);
            drain();
        end

        if (errors == 0)
            $display("weighted_space_saving_counters_core: match");
        else
            $display("weighted_space_saving_counters_core: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("weighted_space_saving_counters_core: mismatch");
        $finish;
    end

endmodule
